// ===== hdl/sws_pkg.sv =====
`timescale 1ns / 1ps

package sws_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam logic [31:0] DEFAULT_INTERVAL = 32'd30;

	localparam int S_TDATA_W = 160;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 176;
	localparam int M_TUSER_W = 5;

	typedef enum logic [2:0] {
		MODE_READING   = 3'd0,
		MODE_PROVISION = 3'd1,
		MODE_ADD       = 3'd2,
		MODE_REMOVE    = 3'd3,
		MODE_SET_ONE   = 3'd4,
		MODE_SET_ALL   = 3'd5,
		MODE_QUERY     = 3'd6,
		MODE_IGNORED   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_UNKNOWN   = 3'd1,
		STAT_ALREADY   = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REPLY_NONE       = 2'd0,
		REPLY_CORRECTION = 2'd1,
		REPLY_PROV_ACK   = 2'd2
	} reply_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_EXEC,
		FSM_SHIFT,
		FSM_SETALL,
		FSM_DIV,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [31:0] interval;
		logic [31:0] anchor;
		logic [31:0] seen_sec;
	} entry_t;

	typedef struct packed {
		status_t     status;
		reply_t      reply;
		logic [31:0] delay;
		logic [31:0] interval;
		logic [31:0] anchor;
		logic [47:0] mac;
		logic [15:0] distance;
		logic [4:0]  slot;
		logic [5:0]  count;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== hdl/sws_div.sv =====
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle, one for each dividend bit, with done raised
// in the cycle after the last step.
module sws_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sws_pkg::div_req_t  req,
	output sws_pkg::div_rsp_t  rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dnd_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, dnd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dnd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dnd_q <= {dnd_q[30:0], 1'b0};
			// The partial remainder always stays below the divisor, so 32 bits hold it.
			if (trial >= {1'b0, dvs_q})
				rem_q <= 32'(trial - {1'b0, dvs_q});
			else
				rem_q <= trial[31:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== hdl/sensor_wake_schedule_table_top.sv =====
`timescale 1ns / 1ps
// Steps: take the item, search the table one entry per cycle (up to MAX_ENTRIES), act,
// then run the remainder unit for a matched reading or provision request, or shift or rewrite
// one entry per cycle for remove and set all, and post the result.
// Throughput: one item at a time, taking no new item until the result is posted.
// Reset clears the entry count and sets the default schedule to 30 s at anchor 0; table
// contents stay undefined until written and need no clearing pass.
module sensor_wake_schedule_table_top #(
	parameter int MAX_ENTRIES = sws_pkg::MAX_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// mac, now_sec, reading value, new interval, anchor_sec
	input  logic [sws_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// mode
	input  logic [sws_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// delay_sec, interval_out, anchor_out, mac_out, distance_out, slot_found,
	// entry_count, zero fill
	output logic [sws_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status, reply_kind
	output logic [sws_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

	localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int DEPTH = 2 ** IW;

	sws_pkg::fsm_t    state_q, state_d;
	sws_pkg::mode_t   mode_q;
	sws_pkg::entry_t  mem_q [DEPTH];
	sws_pkg::entry_t  rd_data_q, ent_q, wr_data;
	sws_pkg::result_t res_q, out_q;
	sws_pkg::div_req_t div_req;
	sws_pkg::div_rsp_t div_rsp;

	logic [CW-1:0] count_q;
	logic [31:0]   def_iv_q, def_an_q;
	logic [47:0]   mac_q;
	logic [31:0]   now_q, niv_q, nan_q;
	logic          found_q, neg_q, out_vld_q;
	logic [IW-1:0] slot_q, ptr_q, rd_addr, wr_addr;
	logic          wr_en, match, last, full, accept, load;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign load   = (state_q == sws_pkg::FSM_FINISH) && (!out_vld_q || m_axis_tready);
	assign match  = (rd_data_q.addr == mac_q);
	assign last   = (CW'(ptr_q) == count_q - CW'(1));
	assign full   = (count_q == CW'(MAX_ENTRIES));

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end

	sws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sws_pkg::FSM_IDLE: begin
				if (s_axis_tvalid)
					state_d = (count_q == '0) ? sws_pkg::FSM_EXEC : sws_pkg::FSM_SEARCH;
			end
			sws_pkg::FSM_SEARCH: begin
				if (match || last)
					state_d = sws_pkg::FSM_EXEC;
			end
			sws_pkg::FSM_EXEC: begin
				state_d = sws_pkg::FSM_FINISH;
				unique case (mode_q)
					sws_pkg::MODE_READING, sws_pkg::MODE_PROVISION: begin
						if (found_q && ent_q.interval != '0)
							state_d = sws_pkg::FSM_DIV;
					end
					sws_pkg::MODE_REMOVE: begin
						if (found_q && CW'(slot_q) != count_q - CW'(1))
							state_d = sws_pkg::FSM_SHIFT;
					end
					sws_pkg::MODE_SET_ALL: begin
						if (count_q != '0)
							state_d = sws_pkg::FSM_SETALL;
					end
					default: ;
				endcase
			end
			sws_pkg::FSM_SHIFT: begin
				// The count has already dropped by one, so it names the last source entry.
				if (CW'(ptr_q) == count_q)
					state_d = sws_pkg::FSM_FINISH;
			end
			sws_pkg::FSM_SETALL: begin
				if (last)
					state_d = sws_pkg::FSM_FINISH;
			end
			sws_pkg::FSM_DIV: begin
				if (div_rsp.done)
					state_d = sws_pkg::FSM_FINISH;
			end
			sws_pkg::FSM_FINISH: begin
				if (!out_vld_q || m_axis_tready)
					state_d = sws_pkg::FSM_IDLE;
			end
			default: state_d = sws_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == sws_pkg::FSM_IDLE);
		rd_addr       = '0;
		wr_en         = 1'b0;
		wr_addr       = slot_q;
		wr_data       = ent_q;
		div_req.start = 1'b0;
		div_req.divisor  = ent_q.interval;
		div_req.dividend = (now_q >= ent_q.anchor) ? now_q - ent_q.anchor
		                                           : ent_q.anchor - now_q;
		unique case (state_q)
			sws_pkg::FSM_SEARCH, sws_pkg::FSM_SETALL: rd_addr = ptr_q + IW'(1);
			sws_pkg::FSM_SHIFT: begin
				rd_addr = ptr_q + IW'(1);
				wr_en   = 1'b1;
				wr_addr = ptr_q - IW'(1);
				wr_data = rd_data_q;
			end
			sws_pkg::FSM_EXEC: begin
				unique case (mode_q)
					sws_pkg::MODE_READING, sws_pkg::MODE_PROVISION: begin
						wr_en = found_q;
						wr_data.seen_sec = now_q;
						div_req.start = found_q && (ent_q.interval != '0);
					end
					sws_pkg::MODE_ADD: begin
						wr_en   = !found_q && !full;
						wr_addr = IW'(count_q);
						wr_data = '{addr: mac_q, interval: def_iv_q, anchor: def_an_q,
						            seen_sec: 32'd0};
					end
					sws_pkg::MODE_REMOVE: rd_addr = slot_q + IW'(1);
					sws_pkg::MODE_SET_ONE: begin
						wr_en = found_q;
						wr_data.interval = niv_q;
						wr_data.anchor   = nan_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (state_q == sws_pkg::FSM_SETALL) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_data = '{addr: rd_data_q.addr, interval: niv_q, anchor: nan_q,
			            seen_sec: rd_data_q.seen_sec};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sws_pkg::FSM_IDLE;
			count_q   <= '0;
			def_iv_q  <= sws_pkg::DEFAULT_INTERVAL;
			def_an_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
			if (state_q == sws_pkg::FSM_EXEC) begin
				unique case (mode_q)
					sws_pkg::MODE_ADD: begin
						if (!found_q && !full)
							count_q <= count_q + CW'(1);
					end
					sws_pkg::MODE_REMOVE: begin
						if (found_q)
							count_q <= count_q - CW'(1);
					end
					sws_pkg::MODE_SET_ALL: begin
						def_iv_q <= niv_q;
						def_an_q <= nan_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sws_pkg::FSM_IDLE: begin
				if (accept) begin
					mode_q  <= sws_pkg::mode_t'(s_axis_tuser[2:0]);
					mac_q   <= s_axis_tdata[47:0];
					now_q   <= s_axis_tdata[79:48];
					niv_q   <= s_axis_tdata[127:96];
					nan_q   <= s_axis_tdata[159:128];
					found_q <= 1'b0;
					slot_q  <= '0;
					ptr_q   <= '0;
					res_q   <= '{status: sws_pkg::STAT_OK, reply: sws_pkg::REPLY_NONE,
					            delay: 32'd0, interval: 32'd0, anchor: 32'd0,
					            mac: s_axis_tdata[47:0],
					            distance: (s_axis_tuser[2:0] == sws_pkg::MODE_READING)
					                      ? s_axis_tdata[95:80] : 16'd0,
					            slot: 5'd0, count: 6'd0};
				end
			end
			sws_pkg::FSM_SEARCH: begin
				if (match) begin
					found_q <= 1'b1;
					slot_q  <= ptr_q;
					ent_q   <= rd_data_q;
				end else begin
					ptr_q <= ptr_q + IW'(1);
				end
			end
			sws_pkg::FSM_EXEC: begin
				neg_q <= (now_q < ent_q.anchor);
				unique case (mode_q)
					sws_pkg::MODE_READING, sws_pkg::MODE_PROVISION: begin
						if (found_q) begin
							res_q.slot     <= 5'(slot_q);
							res_q.interval <= ent_q.interval;
							res_q.anchor   <= ent_q.anchor;
							res_q.delay    <= 32'd1;
							res_q.reply    <= (mode_q == sws_pkg::MODE_READING)
							                  ? sws_pkg::REPLY_CORRECTION
							                  : sws_pkg::REPLY_PROV_ACK;
						end else begin
							res_q.status <= sws_pkg::STAT_UNKNOWN;
						end
					end
					sws_pkg::MODE_ADD: begin
						if (found_q) begin
							res_q.status   <= sws_pkg::STAT_ALREADY;
							res_q.slot     <= 5'(slot_q);
							res_q.interval <= ent_q.interval;
							res_q.anchor   <= ent_q.anchor;
						end else if (full) begin
							res_q.status <= sws_pkg::STAT_FULL;
						end else begin
							res_q.slot     <= 5'(count_q);
							res_q.interval <= def_iv_q;
							res_q.anchor   <= def_an_q;
						end
					end
					sws_pkg::MODE_REMOVE: begin
						ptr_q <= slot_q + IW'(1);
						if (found_q)
							res_q.slot <= 5'(slot_q);
						else
							res_q.status <= sws_pkg::STAT_NOT_FOUND;
					end
					sws_pkg::MODE_SET_ONE: begin
						if (found_q) begin
							res_q.slot     <= 5'(slot_q);
							res_q.interval <= niv_q;
							res_q.anchor   <= nan_q;
						end else begin
							res_q.status <= sws_pkg::STAT_NOT_FOUND;
						end
					end
					sws_pkg::MODE_SET_ALL: begin
						ptr_q          <= '0;
						res_q.interval <= niv_q;
						res_q.anchor   <= nan_q;
					end
					sws_pkg::MODE_QUERY: begin
						if (found_q) begin
							res_q.slot     <= 5'(slot_q);
							res_q.interval <= ent_q.interval;
							res_q.anchor   <= ent_q.anchor;
						end else begin
							res_q.status   <= sws_pkg::STAT_NOT_FOUND;
							res_q.interval <= def_iv_q;
							res_q.anchor   <= def_an_q;
						end
					end
					default: ;
				endcase
			end
			sws_pkg::FSM_SHIFT, sws_pkg::FSM_SETALL: ptr_q <= ptr_q + IW'(1);
			sws_pkg::FSM_DIV: begin
				// Before the anchor the floored remainder is the interval minus the
				// magnitude's remainder, which leaves that remainder as the delay.
				if (div_rsp.done) begin
					if (!neg_q)
						res_q.delay <= res_q.interval - div_rsp.rem;
					else if (div_rsp.rem == '0)
						res_q.delay <= res_q.interval;
					else
						res_q.delay <= div_rsp.rem;
				end
			end
			sws_pkg::FSM_FINISH: begin
				if (load)
					out_q <= '{status: res_q.status, reply: res_q.reply,
					           delay: res_q.delay, interval: res_q.interval,
					           anchor: res_q.anchor, mac: res_q.mac,
					           distance: res_q.distance, slot: res_q.slot,
					           count: 6'(count_q)};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_q.count, out_q.slot, out_q.distance, out_q.mac,
	                        out_q.anchor, out_q.interval, out_q.delay};
	assign m_axis_tuser  = {out_q.reply, out_q.status};

endmodule

// ===== hdl/sws_chk.sv =====
`timescale 1ns / 1ps

module sws_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [sws_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [sws_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [sws_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [sws_pkg::M_TUSER_W-1:0] m_axis_tuser
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// One item at a time: the input is closed in the cycle after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input reopened straight after a transfer");

	// A reply is only ever sent with an ok status.
	a_reply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4:3] != sws_pkg::REPLY_NONE
		|-> m_axis_tuser[2:0] == sws_pkg::STAT_OK)
		else $error("reply carries an error status");

	// A reply never schedules a wake with a zero delay.
	a_delay_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4:3] != sws_pkg::REPLY_NONE
		|-> m_axis_tdata[31:0] != 32'd0)
		else $error("reply with zero delay");

endmodule

bind sensor_wake_schedule_table_top sws_chk u_sws_chk (.*);
